FILE: hdl/rdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_pkg: shared definitions of the radix digit converter
// Field widths, radix limits, character codes, the controller state type and
// the mapping from a digit value to its ASCII character.
// ----------------------------------------------------------------------------
package rdc_pkg;

    // Width of the value to convert and of the bit counter over it.
    localparam int VALUE_W   = 63;
    localparam int BIT_CNT_W = 6;
    localparam logic [BIT_CNT_W-1:0] BIT_LAST = BIT_CNT_W'(VALUE_W - 1);

    // Digit and radix widths.
    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 7;
    localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd2;

    // Character codes.
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
    localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
    localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FETCH,
        ST_LOAD
    } rdc_state_t;

    // Map a digit value (below thirty-six) to '0'-'9' or 'A'-'Z'.
    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] digit);
        logic [CHAR_W-1:0] wide_digit;
        wide_digit = {1'b0, digit};
        if (digit < DEC_DIGITS)
        begin
            return ASCII_ZERO + wide_digit;
        end
        return (ASCII_A - {1'b0, DEC_DIGITS}) + wide_digit;
    endfunction

endpackage
`default_nettype wire

FILE: hdl/radix_digit_converter_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// radix_digit_converter_core: integer to radix string converter
// Converts a 63-bit non-negative integer to ASCII digits of radix 2 to 36,
// most significant digit first, flagging the final digit.
// ----------------------------------------------------------------------------
// A conversion starts when start is high while busy is low. The value is
// divided by the radix over and over with a bit-serial restoring divider that
// retires one quotient bit per cycle; the remainders go into a small digit
// RAM. The digits are then read back from the RAM, most significant first,
// each read in ST_FETCH and presented from ST_LOAD, and each appears on
// digit_char for exactly one cycle with digit_valid high; last_digit marks the
// least significant one. The receiver cannot stall the output, so it must take
// every beat as it comes. A zero input yields a single '0'. Radix settings
// below two act as two and above thirty-six as thirty-six. At most
// min(MAX_DIGITS, 63) digits are produced; a value that needs more yields
// only its least significant digits. Write base_radix only while busy is low
// and no beat is pending.
// ----------------------------------------------------------------------------
module radix_digit_converter_core #(
    parameter int MAX_DIGITS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rdc_pkg::VALUE_W-1:0]   value_in,
    input  wire logic                          base_radix_wr_en,
    input  wire logic [rdc_pkg::RADIX_W-1:0]   base_radix_wr_data,
    output logic                               digit_valid,
    output logic      [rdc_pkg::CHAR_W-1:0]    digit_char,
    output logic                               last_digit
);

    import rdc_pkg::*;

    localparam int DIGIT_LIMIT = (MAX_DIGITS < VALUE_W) ? MAX_DIGITS : VALUE_W;
    localparam int ADDR_W      = $clog2(MAX_DIGITS);
    localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
    localparam logic [CNT_W-1:0] LAST_SLOT = CNT_W'(DIGIT_LIMIT - 1);

    rdc_state_t state_reg, state_next;

    logic [RADIX_W-1:0]   base_radix_reg;
    logic [RADIX_W-1:0]   radix;
    logic [VALUE_W-1:0]   quot_reg, quot_next;
    logic [RADIX_W-1:0]   rem_reg, rem_next;
    logic [BIT_CNT_W-1:0] bit_cnt_reg, bit_cnt_next;
    logic                 nz_reg, nz_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [ADDR_W-1:0]    pos_reg, pos_next;
    logic                 strobe_reg, strobe_next;
    logic [CHAR_W-1:0]    char_reg, char_next;
    logic                 last_reg, last_next;

    logic [RADIX_W:0]     rem_shift;
    logic [RADIX_W:0]     rem_diff;
    logic                 quot_bit;
    logic [RADIX_W-1:0]   rem_step;
    logic                 ram_wr_en;
    logic                 ram_rd_en;
    logic [RADIX_W-1:0]   ram_rd_data;

    // Radix register, written directly from the configuration port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_radix_reg <= RADIX_RESET;
        end
        else if (base_radix_wr_en)
        begin
            base_radix_reg <= base_radix_wr_data;
        end
    end

    // Saturate the radix into the supported range.
    always_comb
    begin
        priority if (base_radix_reg < RADIX_MIN)
        begin
            radix = RADIX_MIN;
        end
        else if (base_radix_reg > RADIX_MAX)
        begin
            radix = RADIX_MAX;
        end
        else
        begin
            radix = base_radix_reg;
        end
    end

    // One restoring division step: bring down the top quotient bit.
    assign rem_shift = {rem_reg, quot_reg[VALUE_W-1]};
    assign rem_diff  = rem_shift - {1'b0, radix};
    assign quot_bit  = (rem_shift >= {1'b0, radix});
    assign rem_step  = quot_bit ? rem_diff[RADIX_W-1:0] : rem_shift[RADIX_W-1:0];

    // Digit store.
    rdc_ram #(
        .WIDTH(RADIX_W),
        .DEPTH(MAX_DIGITS)
    ) u_digit_ram (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(count_reg[ADDR_W-1:0]),
        .wr_data(rem_step),
        .rd_en  (ram_rd_en),
        .rd_addr(pos_reg),
        .rd_data(ram_rd_data)
    );

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            nz_reg      <= 1'b0;
            count_reg   <= '0;
            pos_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            nz_reg      <= nz_next;
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    // Next state and controls.
    always_comb
    begin
        state_next   = state_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        bit_cnt_next = bit_cnt_reg;
        nz_next      = nz_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        ram_wr_en    = 1'b0;
        ram_rd_en    = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    quot_next    = value_in;
                    rem_next     = '0;
                    bit_cnt_next = '0;
                    nz_next      = 1'b0;
                    count_next   = '0;
                    state_next   = ST_DIVIDE;
                end
            end

            ST_DIVIDE:
            begin
                quot_next    = {quot_reg[VALUE_W-2:0], quot_bit};
                rem_next     = rem_step;
                nz_next      = nz_reg | quot_bit;
                bit_cnt_next = bit_cnt_reg + 1'b1;
                if (bit_cnt_reg == BIT_LAST)
                begin
                    // Remainder is the next digit; store it and decide whether to go on.
                    ram_wr_en  = 1'b1;
                    pos_next   = count_reg[ADDR_W-1:0];
                    count_next = count_reg + 1'b1;
                    if ((nz_reg | quot_bit) && (count_reg < LAST_SLOT))
                    begin
                        rem_next     = '0;
                        bit_cnt_next = '0;
                        nz_next      = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end

            ST_FETCH:
            begin
                ram_rd_en  = 1'b1;
                state_next = ST_LOAD;
            end

            ST_LOAD:
            begin
                // Read data is back: present the beat for one cycle.
                char_next   = digit_to_ascii(ram_rd_data);
                last_next   = (pos_reg == '0);
                strobe_next = 1'b1;
                if (pos_reg == '0)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    pos_next   = pos_reg - 1'b1;
                    state_next = ST_FETCH;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs.
    assign busy        = (state_reg != ST_IDLE);
    assign digit_valid = strobe_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;

endmodule
`default_nettype wire

FILE: hdl/rdc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rdc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rdc_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: bench/tb_radix_digit_converter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radix_digit_converter_core: self-checking bench of the radix converter
// Drives integers into the converter under a range of radix settings and
// checks every digit beat against a behavioural prediction kept in a small
// scoreboard. A directed pass covers the field extremes, zero and radix
// saturation. Random passes follow with sender gaps and drain pauses.
// ----------------------------------------------------------------------------
module tb_radix_digit_converter_core;

    import rdc_pkg::*;

    localparam int MAX_DIGITS   = 64;
    localparam int DIGIT_LIMIT  = (MAX_DIGITS < 63) ? MAX_DIGITS : 63;
    localparam int CYCLE_LIMIT  = 3_000_000;
    localparam int TAIL_CYCLES  = 4200;
    localparam int RAND_PHASES  = 6;
    localparam int PHASE_ITEMS  = 17;
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    // One expected digit beat.
    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_beat_t;

    // Scoreboard: predicts the digit string of each accepted value and
    // compares the beats that come out of the converter in order.
    class digit_scoreboard;
        digit_beat_t       pending_digits[$];
        logic [RADIX_W-1:0] radix_setting;
        int unsigned       mismatch_count;

        function new();
            radix_setting  = RADIX_RESET;
            mismatch_count = 0;
        endfunction

        function void set_radix(logic [RADIX_W-1:0] setting);
            radix_setting = setting;
        endfunction

        // Settings outside two to thirty-six saturate.
        function logic [RADIX_W-1:0] working_radix();
            if (radix_setting < RADIX_MIN)
            begin
                return RADIX_MIN;
            end
            if (radix_setting > RADIX_MAX)
            begin
                return RADIX_MAX;
            end
            return radix_setting;
        endfunction

        function int pending();
            return pending_digits.size();
        endfunction

        // Repeated division; the remainders come out least significant first.
        function void note_value(logic [VALUE_W-1:0] value);
            logic [RADIX_W-1:0] remainders[$];
            logic [VALUE_W-1:0] quot;
            logic [VALUE_W-1:0] radix;
            logic [RADIX_W-1:0] digit;
            digit_beat_t        beat;
            int                 k;
            radix = VALUE_W'(working_radix());
            quot  = value;
            if (quot == '0)
            begin
                remainders.push_back('0);
            end
            while (quot != '0 && remainders.size() < DIGIT_LIMIT)
            begin
                remainders.push_back(RADIX_W'(quot % radix));
                quot = quot / radix;
            end
            for (k = remainders.size() - 1; k >= 0; k--)
            begin
                digit = remainders[k];
                if (digit < DEC_DIGITS)
                begin
                    beat.code = ASCII_ZERO + CHAR_W'(digit);
                end
                else
                begin
                    beat.code = ASCII_A + CHAR_W'(digit - DEC_DIGITS);
                end
                beat.last = (k == 0);
                pending_digits.push_back(beat);
            end
        endfunction

        function void check_digit(logic [CHAR_W-1:0] code, logic last);
            digit_beat_t want;
            if (pending_digits.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, actual char %0d last %0b",
                         $time, code, last);
                mismatch_count++;
                return;
            end
            want = pending_digits.pop_front();
            if (code !== want.code)
            begin
                $display("%0t: digit_char mismatch, expected %0d, actual %0d",
                         $time, want.code, code);
                mismatch_count++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_digit mismatch, expected %0b, actual %0b",
                         $time, want.last, last);
                mismatch_count++;
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic [VALUE_W-1:0]  value_in = '0;
    logic                base_radix_wr_en = 1'b0;
    logic [RADIX_W-1:0]  base_radix_wr_data = '0;
    logic                busy;
    logic                digit_valid;
    logic [CHAR_W-1:0]   digit_char;
    logic                last_digit;
    int unsigned         cycle_count = 0;

    digit_scoreboard book = new();

    radix_digit_converter_core #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .value_in           (value_in),
        .base_radix_wr_en   (base_radix_wr_en),
        .base_radix_wr_data (base_radix_wr_data),
        .digit_valid        (digit_valid),
        .digit_char         (digit_char),
        .last_digit         (last_digit)
    );

    // 10 ns clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Every digit beat is taken at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && digit_valid)
        begin
            book.check_digit(digit_char, last_digit);
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Present one value and hold it until the converter takes the beat.
    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        start    <= 1'b1;
        value_in <= value;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        book.note_value(value);
        @(negedge clk);
    endtask

    // Drop start and wait until every predicted beat has come out.
    task automatic drain_digits();
        start <= 1'b0;
        while (book.pending() != 0 || busy)
        begin
            @(negedge clk);
        end
    endtask

    // Radix writes only happen with the converter drained.
    task automatic write_radix(input logic [RADIX_W-1:0] setting);
        drain_digits();
        base_radix_wr_en   <= 1'b1;
        base_radix_wr_data <= setting;
        @(negedge clk);
        base_radix_wr_en   <= 1'b0;
        book.set_radix(setting);
    endtask

    // Random gap before the next beat, and now and then a full drain.
    task automatic sender_gap(input int idle_pct);
        int gap;
        if ($urandom_range(0, 15) == 0)
        begin
            drain_digits();
        end
        else if ($urandom_range(0, 99) < idle_pct)
        begin
            gap   = $urandom_range(1, 40);
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    // Random values: full width, narrowed, zero, or next to a radix power.
    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0]        raw;
        logic [VALUE_W-1:0] mask;
        logic [VALUE_W-1:0] power;
        logic [VALUE_W-1:0] radix;
        int                 width;
        int                 steps;
        raw   = {$urandom, $urandom};
        width = $urandom_range(1, VALUE_W);
        mask  = (width == VALUE_W) ? VALUE_MAX : ((VALUE_W'(1) << width) - 1);
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return raw[VALUE_W-1:0];
            3, 4:
            begin
                radix = VALUE_W'(book.working_radix());
                power = VALUE_W'(1);
                steps = $urandom_range(1, VALUE_W);
                repeat (steps)
                begin
                    if (power <= VALUE_MAX / radix)
                    begin
                        power = power * radix;
                    end
                end
                return power - VALUE_W'($urandom_range(0, 1));
            end
            default: return raw[VALUE_W-1:0] & mask;
        endcase
    endfunction

    initial
    begin
        int phase;
        int n;
        int idle_pct;

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: reset radix of two, zero and the widest values.
        send_value('0);
        send_value(VALUE_W'(1));
        send_value(VALUE_MAX);
        send_value(VALUE_W'(1) << (VALUE_W - 1));

        // Settings below two saturate to two.
        write_radix(6'd0);
        send_value(VALUE_W'(5));
        write_radix(6'd1);
        send_value(VALUE_W'(6));

        // Top radix: the whole alphabet up to 'Z'.
        write_radix(RADIX_MAX);
        send_value(VALUE_W'(35));
        send_value(VALUE_W'(36));
        send_value(VALUE_W'(1295));
        send_value(VALUE_MAX);

        // Settings above thirty-six saturate to thirty-six.
        write_radix(6'd63);
        send_value('0);
        send_value(VALUE_W'(46655));
        write_radix(6'd37);
        send_value(VALUE_MAX);

        // Decimal, hexadecimal and an odd radix.
        write_radix(6'd10);
        send_value(VALUE_W'(9));
        send_value(VALUE_W'(10));
        send_value(VALUE_W'(1234567890));
        send_value(VALUE_MAX);
        write_radix(6'd16);
        send_value(VALUE_W'(64'hABCDEF));
        send_value(VALUE_MAX);
        write_radix(6'd3);
        send_value(VALUE_MAX);

        // Random phases: sender idles often, then a lot, then never.
        for (phase = 0; phase < RAND_PHASES; phase++)
        begin
            idle_pct = (phase < 2) ? 37 : ((phase < 4) ? 70 : 0);
            write_radix(RADIX_W'($urandom_range(0, 63)));
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                sender_gap(idle_pct);
                send_value(random_value());
            end
        end

        drain_digits();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (book.mismatch_count == 0 && book.pending() == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/rdc_pkg.sv
hdl/rdc_ram.sv
hdl/radix_digit_converter_core.sv
bench/tb_radix_digit_converter_core.sv
